FILE: design/tcdq_pkg.sv
// Package: shared types and constants of the tick clock with delta timeout queue.
`default_nettype none
package tcdq_pkg;
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int MAX_RESULTS = 16;

    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_ADD  = 2'd1;
    localparam logic [1:0] FUNC_SET  = 2'd2;
    localparam logic [1:0] FUNC_NOP  = 2'd3;

    localparam logic [1:0] CFG_WHOLE = 2'd0;
    localparam logic [1:0] CFG_NUM   = 2'd1;
    localparam logic [1:0] CFG_DEN   = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  task_id;
        logic [31:0] timeout;
        logic [63:0] time_value;
    } t_in;

    typedef struct packed {
        logic        status;
        logic        woken_valid;
        logic [7:0]  woken_task;
        logic        last;
        logic [63:0] sys_time;
    } t_out;

    typedef struct packed {
        logic [7:0]       task_id;
        logic [31:0]      delta;
        logic [IDX_W-1:0] nxt;
        logic             has_next;
    } t_entry;
endpackage
`default_nettype wire

FILE: design/tcdq_if.sv
// Interface: valid/ready channel carrying one payload.
`default_nettype none
interface tcdq_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/tcdq_ram.sv
// Generic single-port-write, single-read synchronous RAM with registered read data.
`default_nettype none
module tcdq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: design/tick_clock_with_delta_timeout_queue_top.sv
// Top level: system time keeper with a delta-list timeout queue held in RAM.
//
// One item at a time; the next item is taken only once the last result of the
// previous one has been transferred. A set, a no-op or an add to a full table
// gives its result in the cycle after the item is accepted. A tick reads the
// list head and then releases its waiters (up to 16), one RAM read per list
// entry, before it gives its last result; it holds while the output register is
// occupied. An add to a table with room reads the head, walks the list one RAM
// read per entry (up to 15), writes the new entry and then links it behind a
// predecessor if it has one, as set by the single RAM read and write ports.
// Results leave through one output register.
`default_nettype none
module tick_clock_with_delta_timeout_queue_top
    import tcdq_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    tcdq_if.sink             in_ch,
    tcdq_if.source           out_ch
);
    localparam logic [2:0] S_IDLE = 3'd0, S_TCHK = 3'd1, S_ACHK = 3'd2,
                           S_AWR = 3'd3, S_PWR = 3'd4;

    logic [2:0]  r_st, n_st;
    logic [15:0] r_whole, r_num, r_den;
    logic [63:0] r_time, n_time;
    logic [15:0] r_rem, n_rem;
    logic [IDX_W-1:0] r_head, n_head;
    logic        r_ne, n_ne;
    logic [QUEUE_DEPTH-1:0] r_used, n_used;
    logic [31:0] r_add, n_add;
    logic [4:0]  r_cnt, n_cnt;
    logic [7:0]  r_task, n_task;
    logic [IDX_W-1:0] r_cur, n_cur, r_prev, n_prev, r_slot, n_slot, r_nxt, n_nxt;
    t_entry      r_pe, n_pe;
    logic        r_hprev, n_hprev;
    logic        r_hn, n_hn;
    logic [31:0] r_tmo, n_tmo;
    logic        r_pv, n_pv;
    logic [7:0]  r_pvtask, n_pvtask;
    logic        r_ov, n_ov;
    t_out        r_out, n_out;

    logic             we;
    logic [IDX_W-1:0] waddr, raddr;
    t_entry           wdata, rdata;

    tcdq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH($bits(t_entry))) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic [16:0] rem_sum;
    logic [IDX_W-1:0] free_idx;
    logic        free_any;
    logic        out_free;

    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_idx = IDX_W'(i);
                free_any = 1'b1;
            end
        end
    end

    assign in_ch.ready  = (r_st == S_IDLE) && !r_ov;
    assign out_ch.valid = r_ov;
    assign out_ch.data  = r_out;

    always_comb begin
        n_st = r_st; n_time = r_time; n_rem = r_rem; n_head = r_head; n_ne = r_ne;
        n_used = r_used; n_add = r_add; n_cnt = r_cnt; n_task = r_task; n_cur = r_cur;
        n_prev = r_prev; n_pe = r_pe; n_hprev = r_hprev; n_slot = r_slot;
        n_nxt = r_nxt; n_hn = r_hn; n_tmo = r_tmo; n_pv = r_pv; n_pvtask = r_pvtask;
        n_ov = r_ov; n_out = r_out;
        we = 1'b0; waddr = r_cur; wdata = rdata; raddr = r_cur;
        rem_sum = {1'b0, r_rem} + {1'b0, r_num};
        out_free = !r_ov || out_ch.ready;
        if (r_ov && out_ch.ready) n_ov = 1'b0;
        case (r_st)
            S_IDLE: begin
                if (in_ch.valid && !r_ov) begin
                    n_out = '0;
                    n_out.last = 1'b1;
                    n_out.sys_time = r_time;
                    case (in_ch.data.func)
                        FUNC_TICK: begin
                            if (rem_sum >= {1'b0, r_den}) begin
                                n_add = {16'd0, r_whole} + 32'd1;
                                n_rem = 16'(rem_sum - {1'b0, r_den});
                            end else begin
                                n_add = {16'd0, r_whole};
                                n_rem = rem_sum[15:0];
                            end
                            n_time = r_time + {32'd0, n_add};
                            n_cnt = '0;
                            n_pv = 1'b0;
                            n_cur = r_head;
                            raddr = r_head;
                            n_st = S_TCHK;
                        end
                        FUNC_ADD: begin
                            if (!free_any) begin
                                n_out.status = 1'b1;
                                n_ov = 1'b1;
                            end else begin
                                n_slot = free_idx;
                                n_used[free_idx] = 1'b1;
                                n_task = in_ch.data.task_id;
                                n_tmo = in_ch.data.timeout;
                                n_hprev = 1'b0;
                                n_hn = 1'b0;
                                n_nxt = '0;
                                n_cur = r_head;
                                raddr = r_head;
                                n_st = r_ne ? S_ACHK : S_AWR;
                            end
                        end
                        FUNC_SET: begin
                            n_time = in_ch.data.time_value;
                            n_out.sys_time = in_ch.data.time_value;
                            n_ov = 1'b1;
                        end
                        default: begin
                            n_ov = 1'b1;
                        end
                    endcase
                end
            end
            S_TCHK: begin
                if (r_ne && r_cnt < 5'(MAX_RESULTS) && rdata.delta <= r_add) begin
                    if (!r_pv || out_free) begin
                        if (r_pv) begin
                            n_out = '0;
                            n_out.woken_valid = 1'b1;
                            n_out.woken_task = r_pvtask;
                            n_out.sys_time = r_time;
                            n_ov = 1'b1;
                        end
                        n_pv = 1'b1;
                        n_pvtask = rdata.task_id;
                        n_add = r_add - rdata.delta;
                        n_used[r_cur] = 1'b0;
                        n_cnt = r_cnt + 5'd1;
                        n_ne = rdata.has_next;
                        n_head = rdata.has_next ? rdata.nxt : '0;
                        n_cur = n_head;
                        raddr = n_head;
                    end
                end else if (out_free) begin
                    n_out = '0;
                    n_out.woken_valid = r_pv;
                    n_out.woken_task = r_pv ? r_pvtask : 8'd0;
                    n_out.last = 1'b1;
                    n_out.sys_time = r_time;
                    n_ov = 1'b1;
                    if (r_ne) begin
                        we = 1'b1;
                        waddr = r_cur;
                        wdata = rdata;
                        wdata.delta = (rdata.delta > r_add) ? rdata.delta - r_add : 32'd0;
                    end
                    n_st = S_IDLE;
                end
            end
            S_ACHK: begin
                if (r_tmo < rdata.delta) begin
                    we = 1'b1; waddr = r_cur; wdata = rdata;
                    wdata.delta = rdata.delta - r_tmo;
                    n_nxt = r_cur;
                    n_hn = 1'b1;
                    n_st = S_AWR;
                end else begin
                    n_tmo = r_tmo - rdata.delta;
                    n_prev = r_cur;
                    n_pe = rdata;
                    n_hprev = 1'b1;
                    if (rdata.has_next) begin
                        n_cur = rdata.nxt;
                        raddr = rdata.nxt;
                    end else begin
                        n_nxt = '0;
                        n_hn = 1'b0;
                        n_st = S_AWR;
                    end
                end
            end
            S_AWR: begin
                we = 1'b1;
                waddr = r_slot;
                wdata.task_id = r_task;
                wdata.delta = r_tmo;
                wdata.nxt = r_nxt;
                wdata.has_next = r_hn;
                if (r_hprev) begin
                    n_st = S_PWR;
                end else begin
                    n_head = r_slot;
                    n_ne = 1'b1;
                    n_out = '0;
                    n_out.last = 1'b1;
                    n_out.sys_time = r_time;
                    n_ov = 1'b1;
                    n_st = S_IDLE;
                end
            end
            S_PWR: begin
                we = 1'b1;
                waddr = r_prev;
                wdata = r_pe;
                wdata.nxt = r_slot;
                wdata.has_next = 1'b1;
                n_out = '0;
                n_out.last = 1'b1;
                n_out.sys_time = r_time;
                n_ov = 1'b1;
                n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_whole <= 16'd1; r_num <= 16'd0; r_den <= 16'd1;
            r_time <= '0; r_rem <= '0; r_head <= '0; r_ne <= 1'b0; r_used <= '0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_time <= n_time; r_rem <= n_rem; r_head <= n_head;
            r_ne <= n_ne; r_used <= n_used; r_ov <= n_ov;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WHOLE: r_whole <= i_cfg_data;
                    CFG_NUM:   r_num <= i_cfg_data;
                    CFG_DEN:   r_den <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_add <= n_add; r_cnt <= n_cnt; r_task <= n_task; r_cur <= n_cur;
        r_prev <= n_prev; r_pe <= n_pe; r_hprev <= n_hprev; r_slot <= n_slot;
        r_nxt <= n_nxt; r_hn <= n_hn; r_tmo <= n_tmo; r_pv <= n_pv;
        r_pvtask <= n_pvtask; r_out <= n_out;
    end
endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
// Testbench for the tick clock with delta timeout queue: items checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import tcdq_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = CFG_WHOLE;
    logic [15:0] i_cfg_data = '0;

    tcdq_if #(.T(t_in)) in_ch ();
    tcdq_if #(.T(t_out)) out_ch ();

    tick_clock_with_delta_timeout_queue_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .in_ch(in_ch), .out_ch(out_ch)
    );

    always #4 i_clk = ~i_clk;

    // predictor state
    logic [63:0] clk_ms;
    logic [15:0] frac_rem;
    logic [15:0] whole_ms, frac_num, frac_den;
    logic [7:0]  w_task [QUEUE_DEPTH];
    logic [31:0] w_delta [QUEUE_DEPTH];
    logic [3:0]  w_next [QUEUE_DEPTH];
    logic        w_used [QUEUE_DEPTH];
    logic        w_more [QUEUE_DEPTH];
    logic [3:0]  head;
    logic        busy_list;

    t_in  pending_items [$];
    t_out expected_results [$];
    int   send_idle_pct = 0, recv_stall_pct = 0;
    int   fails = 0, n_items = 0, n_woken = 0, n_full = 0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    function automatic t_out mk(logic st, logic wv, logic [7:0] tk, logic lst);
        t_out r;
        r.status = st; r.woken_valid = wv; r.woken_task = tk;
        r.last = lst; r.sys_time = clk_ms;
        return r;
    endfunction

    task automatic predict_item(input t_in it);
        logic [31:0] elapsed, tmo;
        logic [16:0] rem;
        int n, slot, steps;
        logic have_prev, have_cur;
        logic [3:0] prv, cur, s;
        t_out r;
        n = 0;
        if (it.func == FUNC_TICK) begin
            elapsed = {16'd0, whole_ms};
            rem = {1'b0, frac_rem} + {1'b0, frac_num};
            if (rem >= {1'b0, frac_den}) begin
                elapsed = elapsed + 32'd1;
                rem = rem - {1'b0, frac_den};
            end
            frac_rem = rem[15:0];
            clk_ms = clk_ms + {32'd0, elapsed};
            while (busy_list && n < MAX_RESULTS && w_delta[head] <= elapsed) begin
                elapsed = elapsed - w_delta[head];
                expected_results.push_back(mk(1'b0, 1'b1, w_task[head], 1'b0));
                n++; n_woken++;
                w_used[head] = 1'b0;
                w_delta[head] = '0;
                if (w_more[head]) begin
                    w_more[head] = 1'b0;
                    head = w_next[head];
                end else begin
                    w_more[head] = 1'b0;
                    busy_list = 1'b0;
                    head = '0;
                end
            end
            if (busy_list)
                w_delta[head] = (w_delta[head] > elapsed) ? w_delta[head] - elapsed : '0;
            if (n == 0) begin
                expected_results.push_back(mk(1'b0, 1'b0, 8'd0, 1'b1));
            end else begin
                r = expected_results.pop_back();
                r.last = 1'b1;
                expected_results.push_back(r);
            end
        end else if (it.func == FUNC_ADD) begin
            slot = -1;
            for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
                if (!w_used[i]) slot = i;
            if (slot < 0) begin
                n_full++;
                expected_results.push_back(mk(1'b1, 1'b0, 8'd0, 1'b1));
            end else begin
                s = slot[3:0];
                w_used[s] = 1'b1;
                w_task[s] = it.task_id;
                tmo = it.timeout;
                have_prev = 1'b0; have_cur = busy_list;
                prv = '0; cur = head;
                steps = 0;
                while (have_cur && steps < QUEUE_DEPTH && tmo >= w_delta[cur]) begin
                    tmo = tmo - w_delta[cur];
                    prv = cur; have_prev = 1'b1;
                    have_cur = w_more[cur];
                    cur = w_next[cur];
                    steps++;
                end
                if (have_cur && steps < QUEUE_DEPTH) begin
                    w_delta[cur] = w_delta[cur] - tmo;
                    w_next[s] = cur; w_more[s] = 1'b1;
                end else begin
                    w_next[s] = '0; w_more[s] = 1'b0;
                end
                w_delta[s] = tmo;
                if (have_prev) begin
                    w_next[prv] = s; w_more[prv] = 1'b1;
                end else begin
                    head = s; busy_list = 1'b1;
                end
                expected_results.push_back(mk(1'b0, 1'b0, 8'd0, 1'b1));
            end
        end else begin
            if (it.func == FUNC_SET) clk_ms = it.time_value;
            expected_results.push_back(mk(1'b0, 1'b0, 8'd0, 1'b1));
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!in_ch.valid || in_ch.ready) begin
                if (in_ch.valid) begin
                    predict_item(in_ch.data);
                    n_items++;
                end
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_ch.data <= pending_items.pop_front();
                    in_ch.valid <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected transfer, actual %p", $time, out_ch.data);
                    fails++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (out_ch.data !== exp_r) begin
                        $display("%0t: mismatch, expected %p actual %p",
                                 $time, exp_r, out_ch.data);
                        fails++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic t_in item(logic [1:0] f, logic [7:0] tk, logic [31:0] tmo,
                                 logic [63:0] tv);
        t_in it;
        it.func = f; it.task_id = tk; it.timeout = tmo; it.time_value = tv;
        return it;
    endfunction

    function automatic t_in rand_item(int pct_tick, int max_tmo);
        int r;
        r = $urandom_range(99);
        if (r < pct_tick)
            return item(FUNC_TICK, 8'($urandom), $urandom, {$urandom, $urandom});
        if (r < 92)
            return item(FUNC_ADD, 8'($urandom), $urandom_range(max_tmo),
                        {$urandom, $urandom});
        if (r < 97)
            return item(FUNC_SET, 8'($urandom), $urandom, {$urandom, $urandom});
        return item(FUNC_NOP, 8'($urandom), $urandom, {$urandom, $urandom});
    endfunction

    task automatic drain();
        while (pending_items.size() > 0 || in_ch.valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_WHOLE) whole_ms = val;
        else if (idx == CFG_NUM) frac_num = val;
        else frac_den = val;
    endtask

    initial begin
        clk_ms = '0; frac_rem = '0; head = '0; busy_list = 1'b0;
        whole_ms = 16'd1; frac_num = '0; frac_den = 16'd1;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_used[i] = 1'b0; w_more[i] = 1'b0; w_delta[i] = '0;
            w_next[i] = '0; w_task[i] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset rates, extremes, fill beyond capacity, burst release
        pending_items.push_back(item(FUNC_TICK, 8'd0, '0, '0));
        pending_items.push_back(item(FUNC_SET, 8'd0, '0, 64'hFFFF_FFFF_FFFF_FFFF));
        pending_items.push_back(item(FUNC_TICK, 8'd0, '0, '0));
        pending_items.push_back(item(FUNC_NOP, 8'hFF, 32'hFFFF_FFFF, '1));
        pending_items.push_back(item(FUNC_ADD, 8'hFF, 32'hFFFF_FFFF, '0));
        for (int i = 0; i < 16; i++)
            pending_items.push_back(item(FUNC_ADD, i[7:0], 32'(i % 3), '0));
        pending_items.push_back(item(FUNC_TICK, 8'd0, '0, '0));
        pending_items.push_back(item(FUNC_TICK, 8'd0, '0, '0));
        pending_items.push_back(item(FUNC_TICK, 8'd0, '0, '0));
        drain();

        // max rates, zero denominator wraps remainder
        write_reg(CFG_WHOLE, 16'hFFFF);
        write_reg(CFG_NUM, 16'hFFFF);
        write_reg(CFG_DEN, 16'd0);
        for (int i = 0; i < 40; i++) pending_items.push_back(rand_item(30, 200000));
        drain();

        write_reg(CFG_WHOLE, 16'd0);
        write_reg(CFG_NUM, 16'd3);
        write_reg(CFG_DEN, 16'hFFFF);
        for (int i = 0; i < 20; i++) pending_items.push_back(rand_item(40, 3));
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1) ? 66 : ((ph == 3) ? 7 : 0);
            recv_stall_pct = (ph == 2) ? 66 : ((ph == 3) ? 7 : 0);
            write_reg(CFG_WHOLE, 16'($urandom_range(8)));
            write_reg(CFG_NUM, 16'($urandom_range(16)));
            write_reg(CFG_DEN, 16'($urandom_range(1, 10)));
            for (int i = 0; i < 21; i++) pending_items.push_back(rand_item(45, 40));
            drain();
        end

        $display("Transferred %0d items, %0d tasks released, %0d adds rejected as full.",
                 n_items, n_woken, n_full);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire
